>>> hw/rtl/qmn_pkg.sv
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared types and constants for the normalized quaternion product unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qmn_pkg;

   // component format: signed, two integer bits, the rest fraction
   localparam int COMPONENT_WIDTH = 16;
   localparam int FRAC_BITS       = COMPONENT_WIDTH - 2;

   // request codes
   localparam logic REQ_MULTIPLY = 1'b0;
   localparam logic REQ_DIVIDE   = 1'b1;

   typedef logic signed [COMPONENT_WIDTH-1:0] qmn_comp_type;

   typedef struct packed {
      logic         req_type;
      qmn_comp_type a_w;
      qmn_comp_type a_x;
      qmn_comp_type a_y;
      qmn_comp_type a_z;
      qmn_comp_type b_w;
      qmn_comp_type b_x;
      qmn_comp_type b_y;
      qmn_comp_type b_z;
   } qmn_req_type;

   typedef struct packed {
      qmn_comp_type res_w;
      qmn_comp_type res_x;
      qmn_comp_type res_y;
      qmn_comp_type res_z;
      logic         zero_norm;
   } qmn_rsp_type;

   // hamilton product: component c sums a[t] * b[TERM_B[c][t]], negated where TERM_NEG
   localparam logic [1:0] TERM_B [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   localparam logic TERM_NEG [4][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

endpackage

`default_nettype wire

>>> hw/rtl/quaternion_multiply_normalize_unit.sv
// Stages: partial products, signed sums, square partials, squared magnitudes, norm,
// one digit stage per result bit, output. Throughput: one request per cycle, until
// a stalled result fills every stage. A stalled result leaves earlier bubbles free,
// so requests keep entering until every stage holds an item.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_unit
// Hamilton product (or product with the conjugate of B) scaled to unit length,
// with each output correctly rounded, halves away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_multiply_normalize_unit
   import qmn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  qmn_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output qmn_rsp_type rsp_data
);

   localparam int W   = COMPONENT_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int BW  = W + 1;             // conjugated b component
   localparam int PRW = 2 * W + 1;         // one partial product
   localparam int PW  = 2 * W + 2;         // signed product component
   localparam int MW  = 2 * W + 1;         // product magnitude
   localparam int HW  = W + 1;             // low half of magnitude
   localparam int SW  = 4 * W + 2;         // squared magnitude
   localparam int NW  = 4 * W + 4;         // squared norm
   localparam int RW  = 4 * W + 2 * F + 6; // residual of the root recurrence
   localparam int DS  = 5;                 // first digit stage
   localparam int NS  = F + 7;             // stage count

   localparam logic signed [W-1:0] RES_MAX = W'(1) << F;
   localparam logic signed [W-1:0] RES_MIN = -RES_MAX;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS:0]   ld;

   // stage load chain: a stage loads when empty or when its item moves on
   always_comb begin
      ld[NS] = !rsp_stall;
      for (int k = NS - 1; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   always_comb begin
      v_in[0] = ld[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = ld[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !ld[0];

   // stage 0: sixteen partial products, b conjugated for divide
   logic signed [PRW-1:0] prod_in [4][4];
   logic signed [PRW-1:0] prod_ff [4][4];

   always_comb begin
      logic signed [W-1:0]  aq [4];
      logic signed [W-1:0]  bs [4];
      logic signed [BW-1:0] bq [4];
      aq[0] = req_data.a_w;
      aq[1] = req_data.a_x;
      aq[2] = req_data.a_y;
      aq[3] = req_data.a_z;
      bs[0] = req_data.b_w;
      bs[1] = req_data.b_x;
      bs[2] = req_data.b_y;
      bs[3] = req_data.b_z;
      bq[0] = BW'(bs[0]);
      for (int c = 1; c < 4; c++) begin
         bq[c] = (req_data.req_type == REQ_DIVIDE) ? -BW'(bs[c]) : BW'(bs[c]);
      end
      for (int c = 0; c < 4; c++) begin
         for (int t = 0; t < 4; t++) begin
            prod_in[c][t] = aq[t] * bq[TERM_B[c][t]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         prod_ff <= prod_in;
      end
   end

   // stage 1: signed sums, split into sign and magnitude
   logic [MW-1:0] mag_in [4];
   logic [MW-1:0] mag_ff [4];
   logic [3:0]    neg1_in;
   logic [3:0]    neg1_ff;

   always_comb begin
      logic signed [PW-1:0] acc;
      for (int c = 0; c < 4; c++) begin
         acc = '0;
         for (int t = 0; t < 4; t++) begin
            if (TERM_NEG[c][t]) begin
               acc = acc - PW'(prod_ff[c][t]);
            end else begin
               acc = acc + PW'(prod_ff[c][t]);
            end
         end
         neg1_in[c] = acc[PW-1];
         mag_in[c]  = acc[PW-1] ? MW'(-acc) : MW'(acc);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         mag_ff  <= mag_in;
         neg1_ff <= neg1_in;
      end
   end

   // stage 2: square partial products, magnitude split into two halves
   logic [2*W-1:0] hh_in [4];
   logic [2*W:0]   hl_in [4];
   logic [2*W+1:0] ll_in [4];
   logic [2*W-1:0] hh_ff [4];
   logic [2*W:0]   hl_ff [4];
   logic [2*W+1:0] ll_ff [4];
   logic [3:0]     neg2_ff;

   always_comb begin
      logic [W-1:0]  ph;
      logic [HW-1:0] pl;
      for (int c = 0; c < 4; c++) begin
         ph       = mag_ff[c][MW-1:HW];
         pl       = mag_ff[c][HW-1:0];
         hh_in[c] = ph * ph;
         hl_in[c] = ph * pl;
         ll_in[c] = pl * pl;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         neg2_ff <= neg1_ff;
      end
   end

   // stage 3: squared magnitudes
   logic [SW-1:0] sq_in [4];
   logic [SW-1:0] sq_ff [4];
   logic [3:0]    neg3_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         sq_in[c] = (SW'(hh_ff[c]) << (2 * HW)) + (SW'(hl_ff[c]) << (HW + 1))
                  + SW'(ll_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         sq_ff   <= sq_in;
         neg3_ff <= neg2_ff;
      end
   end

   // root recurrence state, index j is the input of digit stage j
   logic signed [RW-1:0] r_ff    [F+2][4];
   logic signed [RW-1:0] y_ff    [F+2][4];
   logic [F:0]           m_ff    [F+2][4];
   logic [NW-1:0]        n_ff    [F+2];
   logic [3:0]           neg_ff  [F+2];
   logic                 zero_ff [F+2];

   // stage 4: squared norm and starting residuals, r = 4 p^2 2^2F - N, y = -N
   logic [NW-1:0]        nsum_in;
   logic signed [RW-1:0] r0_in [4];
   logic signed [RW-1:0] y0_in [4];

   always_comb begin
      nsum_in = NW'(sq_ff[0]) + NW'(sq_ff[1]) + NW'(sq_ff[2]) + NW'(sq_ff[3]);
      for (int c = 0; c < 4; c++) begin
         r0_in[c] = $signed(RW'(sq_ff[c]) << (2 * F + 2)) - $signed(RW'(nsum_in));
         y0_in[c] = -$signed(RW'(nsum_in));
      end
   end

   always_ff @(posedge clock) begin
      if (ld[DS-1]) begin
         r_ff[0]    <= r0_in;
         y_ff[0]    <= y0_in;
         m_ff[0]    <= '{default: '0};
         n_ff[0]    <= nsum_in;
         neg_ff[0]  <= neg3_ff;
         zero_ff[0] <= (nsum_in == '0);
      end
   end

   // digit stages: one result bit per stage, most significant first;
   // the bit is kept when (2m-1)^2 N stays at or below 4 p^2 2^2F
   for (genvar j = 0; j <= F; j++) begin : g_digit
      localparam int B = F - j;

      logic signed [RW-1:0] r_in [4];
      logic signed [RW-1:0] y_in [4];
      logic [F:0]           m_in [4];

      always_comb begin
         logic signed [RW-1:0] d;
         logic signed [RW-1:0] ns;
         logic                 keep;
         ns = $signed(RW'(n_ff[j]));
         for (int c = 0; c < 4; c++) begin
            d        = (y_ff[j][c] <<< (B + 2)) + (ns <<< (2 * B + 2));
            keep     = !m_ff[j][c][F] && (d <= r_ff[j][c]);
            r_in[c]  = keep ? r_ff[j][c] - d : r_ff[j][c];
            y_in[c]  = keep ? y_ff[j][c] + (ns <<< (B + 1)) : y_ff[j][c];
            m_in[c]  = m_ff[j][c];
            m_in[c][B] = keep;
         end
      end

      always_ff @(posedge clock) begin
         if (ld[DS+j]) begin
            r_ff[j+1]    <= r_in;
            y_ff[j+1]    <= y_in;
            m_ff[j+1]    <= m_in;
            n_ff[j+1]    <= n_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
            zero_ff[j+1] <= zero_ff[j];
         end
      end
   end

   // output stage: apply sign, force zeros for a zero norm
   qmn_rsp_type  rsp_data_in;
   qmn_rsp_type  rsp_data_ff;
   qmn_comp_type res [4];

   always_comb begin
      logic signed [W-1:0] val;
      for (int c = 0; c < 4; c++) begin
         val    = W'(m_ff[F+1][c]);
         res[c] = zero_ff[F+1] ? '0 : (neg_ff[F+1][c] ? -val : val);
      end
      rsp_data_in.res_w     = res[0];
      rsp_data_in.res_x     = res[1];
      rsp_data_in.res_y     = res[2];
      rsp_data_in.res_z     = res[3];
      rsp_data_in.zero_norm = zero_ff[F+1];
   end

   always_ff @(posedge clock) begin
      if (ld[NS-1]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = v_ff[NS-1];
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // input held back only when every stage is full and the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&v_ff) && rsp_stall))
      else $error("request stalled with a free stage");

   // zero norm gives all-zero components
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_norm) |->
         (rsp_data.res_w == '0 && rsp_data.res_x == '0 &&
          rsp_data.res_y == '0 && rsp_data.res_z == '0))
      else $error("zero norm with nonzero component");

   // a nonzero norm leaves at least one nonzero component
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.zero_norm) |->
         (rsp_data.res_w != '0 || rsp_data.res_x != '0 ||
          rsp_data.res_y != '0 || rsp_data.res_z != '0))
      else $error("unit result is all zero");

   // unit length bounds every component by one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.res_w <= RES_MAX && rsp_data.res_w >= RES_MIN &&
          rsp_data.res_x <= RES_MAX && rsp_data.res_x >= RES_MIN &&
          rsp_data.res_y <= RES_MAX && rsp_data.res_y >= RES_MIN &&
          rsp_data.res_z <= RES_MAX && rsp_data.res_z >= RES_MIN))
      else $error("component outside unit range");
`endif

endmodule

`default_nettype wire
